// ===== hdl/bhfdr_pkg.sv =====
package bhfdr_pkg;

  // capacity of one run
  localparam int MAX_ITEMS = 64;

  // field widths
  localparam int VAL_W = 25;
  localparam int TAG_W = 16;

  // memory index, item count (holds MAX_ITEMS itself) and product widths
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int PROD_W = VAL_W + CNT_W;
  localparam int STEP_W = $clog2(PROD_W);

  // stream payload widths, padded to whole bytes
  localparam int S_DATA_W = ((VAL_W + TAG_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((TAG_W + VAL_W + 7) / 8) * 8;
  localparam int M_USER_W = 2;

  // fixed point one in Q1.24
  localparam logic [VAL_W-1:0] ONE_Q24 = VAL_W'(1) << 24;
  localparam logic [VAL_W-1:0] ALPHA_RESET = VAL_W'(838861);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REJECT_MODE = CFG_IDX_W'(1);

  // one stored item
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [VAL_W-1:0] value;
  } entry_t;

  // divider handshake
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== hdl/bhfdr_div.sv =====
module bhfdr_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [bhfdr_pkg::PROD_W-1:0]   dividend,
  input  logic [bhfdr_pkg::CNT_W-1:0]    divisor,
  output bhfdr_pkg::div_status_t         status,
  output logic [bhfdr_pkg::PROD_W-1:0]   quotient
);

  logic [bhfdr_pkg::PROD_W-1:0] quo;
  logic [bhfdr_pkg::CNT_W-1:0]  rem;
  logic [bhfdr_pkg::CNT_W-1:0]  dvs;
  logic [bhfdr_pkg::STEP_W-1:0] step;
  logic                         busy;
  logic                         done;

  logic [bhfdr_pkg::CNT_W:0]    trial;
  logic                         fits;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    trial = {rem, quo[bhfdr_pkg::PROD_W-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == bhfdr_pkg::STEP_W'(bhfdr_pkg::PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[bhfdr_pkg::PROD_W-2:0], fits};
      if (fits) begin
        rem <= bhfdr_pkg::CNT_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[bhfdr_pkg::CNT_W-1:0];
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

// ===== hdl/bh_fdr_adjust_top.sv =====
// Benjamini-Hochberg FDR adjustment. Items (p-value in tdata[24:0], tag in
// tdata[40:25], tlast closing the set) are kept in one 64-entry memory in
// descending p-value order, equal values in arrival order. Inserting an item
// moves every stored entry with a smaller p-value up one place, as the single
// read port of the memory walks the entries one a cycle. Items arriving while
// 64 are stored are dropped and every result of that run carries overflow.
// After the closing item each result takes a memory read, the products p*m
// and k*alpha, and a 32-step restoring division of p*m by the rank k, one
// quotient bit per cycle. A result waits in an output register, so the block
// goes on with the next one while the sink stalls. New items are taken once
// the last result of a run has been handed to the output register. Registers
// are written through the cfg port (index 0 alpha, index 1 reject_mode); the
// user must do so only while idle, which the block itself does not enforce.
module bh_fdr_adjust_top (
  input  logic                              clk,
  input  logic                              rst,
  // input stream; s_tdata: p_value, tag, zero pad
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bhfdr_pkg::S_DATA_W-1:0]    s_tdata,
  input  logic                              s_tlast,
  // result stream; m_tdata: tag_out, adjusted, zero pad
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bhfdr_pkg::M_DATA_W-1:0]    m_tdata,
  // m_tuser: reject, overflow
  output logic [bhfdr_pkg::M_USER_W-1:0]    m_tuser,
  output logic                              m_tlast,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bhfdr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bhfdr_pkg::VAL_W-1:0]       cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CMP    = 7'b0000010,
    ST_PLACE  = 7'b0000100,
    ST_EM_RD  = 7'b0001000,
    ST_EM_MUL = 7'b0010000,
    ST_EM_DIV = 7'b0100000,
    ST_EM_OUT = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration
  logic [bhfdr_pkg::VAL_W-1:0] alpha;
  logic                        reject_mode;

  // run state
  logic [bhfdr_pkg::CNT_W-1:0] count;
  logic                        overflow_seen;
  logic [bhfdr_pkg::VAL_W-1:0] running_min;
  logic [bhfdr_pkg::CNT_W-1:0] pos;
  logic [bhfdr_pkg::IDX_W-1:0] idx;

  // pending item
  bhfdr_pkg::entry_t new_item;
  logic              new_last;

  // memory
  bhfdr_pkg::entry_t           mem [bhfdr_pkg::MAX_ITEMS];
  bhfdr_pkg::entry_t           rdata;
  bhfdr_pkg::entry_t           wdata;
  logic [bhfdr_pkg::IDX_W-1:0] rd_addr;
  logic                        wr_en;

  // emission datapath
  logic [bhfdr_pkg::CNT_W-1:0]  rank;
  logic [bhfdr_pkg::PROD_W-1:0] scaled_mul;
  logic [bhfdr_pkg::PROD_W-1:0] scaled;
  logic [bhfdr_pkg::PROD_W-1:0] kalpha;
  logic [bhfdr_pkg::TAG_W-1:0]  cur_tag;
  logic [bhfdr_pkg::PROD_W-1:0] quotient;
  bhfdr_pkg::div_status_t       div_status;
  logic [bhfdr_pkg::VAL_W-1:0]  min_next;
  logic                         is_last;
  logic                         load;

  // output register
  logic                        out_valid;
  logic [bhfdr_pkg::TAG_W-1:0] out_tag;
  logic [bhfdr_pkg::VAL_W-1:0] out_adj;
  logic                        out_rej;
  logic                        out_ovf;
  logic                        out_last;

  logic                        in_xfer;
  logic                        full;
  logic                        shift;
  logic [bhfdr_pkg::CNT_W-1:0] cnt_dec;
  logic [bhfdr_pkg::CNT_W-1:0] pos_dec2;

  assign in_xfer   = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign full      = (count == bhfdr_pkg::CNT_W'(bhfdr_pkg::MAX_ITEMS));
  assign cnt_dec   = count - 1'b1;
  assign pos_dec2  = pos - bhfdr_pkg::CNT_W'(2);

  // stored entry still below the new p-value moves up one place
  assign shift = (rdata.value < new_item.value);

  // read address: walk down during insertion, walk up during emission
  always_comb begin
    case (state)
      ST_IDLE: rd_addr = cnt_dec[bhfdr_pkg::IDX_W-1:0];
      ST_CMP:  rd_addr = pos_dec2[bhfdr_pkg::IDX_W-1:0];
      default: rd_addr = idx;
    endcase
  end

  // write port: shifted entry or the new item, always at pos
  always_comb begin
    wr_en = (state == ST_CMP) || (state == ST_PLACE);
    wdata = ((state == ST_CMP) && shift) ? rdata : new_item;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos[bhfdr_pkg::IDX_W-1:0]] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // rank and products
  assign rank       = count - {1'b0, idx};
  assign scaled_mul = bhfdr_pkg::PROD_W'(rdata.value) * bhfdr_pkg::PROD_W'(count);
  assign is_last    = (bhfdr_pkg::CNT_W'({1'b0, idx}) + 1'b1 == count);
  assign load       = (state == ST_EM_OUT) && (!out_valid || m_tready);

  always_comb begin
    if (quotient < {{(bhfdr_pkg::PROD_W - bhfdr_pkg::VAL_W){1'b0}}, running_min}) begin
      min_next = quotient[bhfdr_pkg::VAL_W-1:0];
    end else begin
      min_next = running_min;
    end
  end

  bhfdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_EM_MUL),
    .dividend (scaled_mul),
    .divisor  (rank),
    .status   (div_status),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (state == ST_EM_MUL) begin
      scaled  <= scaled_mul;
      kalpha  <= bhfdr_pkg::PROD_W'(rank) * bhfdr_pkg::PROD_W'(alpha);
      cur_tag <= rdata.tag;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (full) begin
            state_next = s_tlast ? ST_EM_RD : ST_IDLE;
          end else if (count == '0) begin
            state_next = ST_PLACE;
          end else begin
            state_next = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (!shift) begin
          state_next = new_last ? ST_EM_RD : ST_IDLE;
        end else if (pos == bhfdr_pkg::CNT_W'(1)) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE:  state_next = new_last ? ST_EM_RD : ST_IDLE;
      ST_EM_RD:  state_next = ST_EM_MUL;
      ST_EM_MUL: state_next = ST_EM_DIV;
      ST_EM_DIV: begin
        if (div_status.done) begin
          state_next = ST_EM_OUT;
        end
      end
      ST_EM_OUT: begin
        if (load) begin
          state_next = is_last ? ST_IDLE : ST_EM_RD;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      overflow_seen <= 1'b0;
      running_min   <= bhfdr_pkg::ONE_Q24;
      pos           <= '0;
      idx           <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          idx <= '0;
          if (in_xfer) begin
            if (full) begin
              overflow_seen <= 1'b1;
            end else begin
              pos <= count;
            end
          end
        end
        ST_CMP: begin
          if (shift) begin
            pos <= pos - 1'b1;
          end else begin
            count <= count + 1'b1;
          end
        end
        ST_PLACE: count <= count + 1'b1;
        ST_EM_OUT: begin
          if (load) begin
            if (is_last) begin
              count         <= '0;
              overflow_seen <= 1'b0;
              running_min   <= bhfdr_pkg::ONE_Q24;
            end else begin
              running_min <= min_next;
              idx         <= idx + 1'b1;
            end
          end
        end
        default: ;
      endcase
      // output register valid
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pending item capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      new_item.value <= s_tdata[bhfdr_pkg::VAL_W-1:0];
      new_item.tag   <= s_tdata[bhfdr_pkg::VAL_W +: bhfdr_pkg::TAG_W];
      new_last       <= s_tlast;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_tag  <= cur_tag;
      out_adj  <= min_next;
      out_rej  <= reject_mode && (scaled <= kalpha);
      out_ovf  <= overflow_seen;
      out_last <= is_last;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha       <= bhfdr_pkg::ALPHA_RESET;
      reject_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bhfdr_pkg::REG_ALPHA:       alpha <= cfg_data;
        bhfdr_pkg::REG_REJECT_MODE: reject_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = bhfdr_pkg::M_DATA_W'({out_adj, out_tag});
  assign m_tuser  = {out_ovf, out_rej};
  assign m_tlast  = out_last;

  // store never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bhfdr_pkg::CNT_W'(bhfdr_pkg::MAX_ITEMS))
    else $error("item count above capacity");

  // running minimum never rises above one
  a_min_bound: assert property (@(posedge clk) disable iff (rst)
    running_min <= bhfdr_pkg::ONE_Q24)
    else $error("running minimum above one");

  // insertion walk stays inside the filled part of the store or its first free slot
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (pos != '0) && (pos <= count))
    else $error("insertion position out of range");

  // handing over the last result closes the run
  a_run_close: assert property (@(posedge clk) disable iff (rst)
    (load && is_last) |=> (count == '0) && (state == ST_IDLE) && m_tlast)
    else $error("run not closed after last result");

endmodule
